### sv/assert_macros.svh
// Assertion helpers shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked check, suspended while reset is held.
`define QAT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds through reset.
`define QAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QAT_ASSERT(lbl, clk, rstn, prop, msg)
`define QAT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### sv/qat_pkg.sv
`timescale 1ns / 1ps
package qat_pkg;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CNT_MAX   = 8'hFF;

  typedef enum logic [1:0] {
    PH_BETWEEN = 2'd0,
    PH_PLAIN   = 2'd1,
    PH_QUOTED  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       arg_end;
    logic       arg_dropped;
    logic       line_done;
    logic [7:0] arg_total;
    logic       last;
  } result_t;

  // Results of one item, in delivery order from slot 0, and how many.
  typedef struct packed {
    logic [1:0]        n;
    result_t [2:0]     slot;
  } dec_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 8'd1;
  endfunction

endpackage

### sv/qat_in_if.sv
`timescale 1ns / 1ps
interface qat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       line_last;

  modport source (output valid, output byte_in, output line_last, input ready);
  modport sink (input valid, input byte_in, input line_last, output ready);
endinterface

### sv/qat_out_if.sv
`timescale 1ns / 1ps
interface qat_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       char_valid;
  logic       arg_end;
  logic       arg_dropped;
  logic       line_done;
  logic [7:0] arg_total;
  logic       last;

  modport source (
    output valid, output char_out, output char_valid, output arg_end,
    output arg_dropped, output line_done, output arg_total, output last,
    input ready
  );
  modport sink (
    input valid, input char_out, input char_valid, input arg_end,
    input arg_dropped, input line_done, input arg_total, input last,
    output ready
  );
endinterface

### sv/qat_decode.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qat_decode (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     byte_in,
  input  logic           line_last,
  input  logic           commit,
  output qat_pkg::dec_t  dec
);

  qat_pkg::phase_t phase_r;
  logic            esc_r;
  logic [7:0]      cnt_r;

  qat_pkg::phase_t ph_p;
  logic            esc_p;
  logic [7:0]      cnt_p;
  logic            hit;
  logic [7:0]      mapped;
  logic            b_chr;
  logic            b_end;
  logic            d_end;
  logic            d_drop;
  logic [7:0]      total;
  logic [3:0]      cand_v;
  qat_pkg::result_t cand [4];

  // Escape map: unmapped bytes leave a literal backslash in front.
  always_comb begin
    hit    = 1'b1;
    mapped = qat_pkg::CH_BSLASH;
    case (byte_in)
      qat_pkg::CH_QUOTE:  mapped = qat_pkg::CH_QUOTE;
      qat_pkg::CH_N:      mapped = qat_pkg::CH_LF;
      qat_pkg::CH_R:      mapped = qat_pkg::CH_CR;
      qat_pkg::CH_T:      mapped = qat_pkg::CH_TAB;
      qat_pkg::CH_BSLASH: mapped = qat_pkg::CH_BSLASH;
      default:            hit = 1'b0;
    endcase
  end

  // Byte handling with no escape open, or after an unknown escape.
  always_comb begin
    ph_p  = phase_r;
    esc_p = 1'b0;
    b_chr = 1'b0;
    b_end = 1'b0;
    if (!esc_r || !hit) begin
      case (phase_r)
        qat_pkg::PH_QUOTED: begin
          if (byte_in == qat_pkg::CH_QUOTE) begin
            ph_p = qat_pkg::PH_PLAIN;
          end else if (byte_in == qat_pkg::CH_BSLASH) begin
            esc_p = 1'b1;
          end else begin
            b_chr = 1'b1;
          end
        end
        default: begin
          if (byte_in == qat_pkg::CH_SPACE) begin
            b_end = (phase_r == qat_pkg::PH_PLAIN);
            ph_p  = qat_pkg::PH_BETWEEN;
          end else if (byte_in == qat_pkg::CH_QUOTE) begin
            ph_p = qat_pkg::PH_QUOTED;
          end else begin
            ph_p = qat_pkg::PH_PLAIN;
            if (byte_in == qat_pkg::CH_BSLASH) begin
              esc_p = 1'b1;
            end else begin
              b_chr = 1'b1;
            end
          end
        end
      endcase
    end
    cnt_p  = b_end ? qat_pkg::sat_inc(cnt_r) : cnt_r;
    d_end  = (ph_p == qat_pkg::PH_PLAIN);
    d_drop = (ph_p == qat_pkg::PH_QUOTED);
    total  = d_end ? qat_pkg::sat_inc(cnt_p) : cnt_p;
  end

  // Candidates in order: escape prefix, byte result, dangling backslash, close.
  always_comb begin
    logic       seen;
    logic [2:0] pos;
    for (int k = 0; k < 4; k++) begin
      cand[k] = '0;
    end
    cand_v = {line_last, line_last & esc_p, b_chr | b_end, esc_r};

    cand[0].char_out   = mapped;
    cand[0].char_valid = 1'b1;
    cand[1].char_out   = b_chr ? byte_in : 8'd0;
    cand[1].char_valid = b_chr;
    cand[1].arg_end    = b_end;
    cand[2].char_out   = qat_pkg::CH_BSLASH;
    cand[2].char_valid = 1'b1;
    cand[3].arg_end     = d_end;
    cand[3].arg_dropped = d_drop;
    cand[3].line_done   = 1'b1;
    cand[3].arg_total   = total;

    seen = 1'b0;
    for (int k = 3; k >= 0; k--) begin
      cand[k].last = cand_v[k] & ~seen;
      seen         = seen | cand_v[k];
    end

    dec = '0;
    pos = 3'd0;
    for (int k = 0; k < 4; k++) begin
      if (cand_v[k] && pos < 3'd3) begin
        dec.slot[pos[1:0]] = cand[k];
        pos = pos + 3'd1;
      end
    end
    dec.n = pos[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= qat_pkg::PH_BETWEEN;
      esc_r   <= 1'b0;
      cnt_r   <= 8'd0;
    end else if (commit) begin
      if (line_last) begin
        phase_r <= qat_pkg::PH_BETWEEN;
        esc_r   <= 1'b0;
        cnt_r   <= 8'd0;
      end else begin
        phase_r <= ph_p;
        esc_r   <= esc_p;
        cnt_r   <= cnt_p;
      end
    end
  end

  `QAT_ASSERT(a_line_clears, clk, rst_n, commit && line_last |=> phase_r == qat_pkg::PH_BETWEEN && !esc_r && cnt_r == 8'd0, "state not cleared after line end")
  `QAT_ASSERT(a_esc_in_arg, clk, rst_n, esc_r |-> phase_r != qat_pkg::PH_BETWEEN, "escape open outside an argument")
  `QAT_ASSERT(a_max_three, clk, rst_n, $countones(cand_v) <= 3, "more than three results for one item")

endmodule

### sv/qat_out_buf.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qat_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  qat_pkg::dec_t    dec,
  input  logic             out_ready,
  output logic             out_valid,
  output qat_pkg::result_t head,
  output logic             can_load
);

  qat_pkg::result_t slot_r [3];
  logic [1:0]       cnt_r;
  logic             pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid & out_ready;
  assign head      = slot_r[0];
  // Take a new item when empty or as the last result leaves this cycle.
  assign can_load  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= dec.n;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r[0] <= dec.slot[0];
      slot_r[1] <= dec.slot[1];
      slot_r[2] <= dec.slot[2];
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  `QAT_ASSERT(a_load_empty, clk, rst_n, load |-> can_load, "load over queued results")
  `QAT_ASSERT(a_last_at_tail, clk, rst_n, out_valid |-> (head.last == (cnt_r == 2'd1)), "last flag not on final result")
  `QAT_ASSERT(a_pop_count, clk, rst_n, pop && !load |=> cnt_r == $past(cnt_r) - 2'd1, "count not advanced on pop")

endmodule

### sv/quoted_argument_tokenizer_core.sv
`timescale 1ns / 1ps
// Command-line tokenizer: one byte in, zero to three results out.
// in_ch (valid/ready) carries byte_in and line_last; line_last marks the
// final byte of a line. out_ch (valid/ready) carries one result per item:
// a decoded argument character, an argument end mark, or the line close
// with arg_total (saturating at 255) and arg_dropped for an open quote.
// last flags the final result caused by an input byte.
// A byte is taken into the input register and decoded there; its results
// load into the result queue once the queue can take them, and the first
// one is then offered on out_ch from the queue head. Throughput: one byte
// per cycle while each byte yields at most one result and out_ch.ready
// stays high. A byte with k results keeps the byte behind it in the input
// register until the last of them leaves the three-entry result queue,
// which drains one result per cycle while out_ch.ready is high. Bytes
// with no result (skipped spaces, quotes, opening backslash) never wait.
// Reset (rst_n low, synchronous) empties the queue and input register and
// returns to between arguments with a zero count. When the receiver stalls
// the head result holds, and in_ch.ready drops once the input register is
// full and the queue cannot take its results.
module quoted_argument_tokenizer_core (
  input  logic clk,
  input  logic rst_n,
  qat_in_if.sink    in_ch,
  qat_out_if.source out_ch
);

  logic             s0_valid_r;
  logic [7:0]       s0_byte_r;
  logic             s0_last_r;
  logic             s0_adv;
  logic             buf_load;
  logic             can_load;
  qat_pkg::dec_t    dec;
  qat_pkg::result_t head;

  // Advance the held byte when its results fit, or when it has none.
  assign s0_adv      = s0_valid_r && ((dec.n == 2'd0) || can_load);
  assign buf_load    = s0_adv && (dec.n != 2'd0);
  assign in_ch.ready = !s0_valid_r || s0_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  // Payload needs no reset; hold it until the item advances.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s0_byte_r <= in_ch.byte_in;
      s0_last_r <= in_ch.line_last;
    end
  end

  qat_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_in   (s0_byte_r),
    .line_last (s0_last_r),
    .commit    (s0_adv),
    .dec       (dec)
  );

  qat_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (buf_load),
    .dec       (dec),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .head      (head),
    .can_load  (can_load)
  );

  // Drive the result channel from the queue head.
  assign out_ch.char_out    = head.char_out;
  assign out_ch.char_valid  = head.char_valid;
  assign out_ch.arg_end     = head.arg_end;
  assign out_ch.arg_dropped = head.arg_dropped;
  assign out_ch.line_done   = head.line_done;
  assign out_ch.arg_total   = head.arg_total;
  assign out_ch.last        = head.last;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  qat_in_if  in_ch ();
  qat_out_if out_ch ();

  quoted_argument_tokenizer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // Hard stop in case the block locks up or loses results.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tokenizer model: its own copy of the lexer state.
  // ---------------------------------------------------------------------
  qat_pkg::phase_t tok_phase = qat_pkg::PH_BETWEEN;
  logic            esc_wait = 1'b0;
  logic [7:0]      arg_cnt = 8'd0;

  // Results still owed by the block, oldest first.
  qat_pkg::result_t owed_results[$];

  int fail_count = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  function automatic qat_pkg::result_t char_item(input logic [7:0] c);
    qat_pkg::result_t r;
    r = '0;
    r.char_out   = c;
    r.char_valid = 1'b1;
    return r;
  endfunction

  function automatic qat_pkg::result_t end_item();
    qat_pkg::result_t r;
    r = '0;
    r.arg_end = 1'b1;
    return r;
  endfunction

  // Count one finished argument; the count sticks at its maximum.
  function automatic void count_arg();
    if (arg_cnt != qat_pkg::CNT_MAX) arg_cnt = arg_cnt + 8'd1;
  endfunction

  // Translate the byte after a backslash; 0 when it is no known escape.
  function automatic logic escape_target(input logic [7:0] c,
                                         output logic [7:0] m);
    m = 8'd0;
    case (c)
      qat_pkg::CH_QUOTE:  m = qat_pkg::CH_QUOTE;
      qat_pkg::CH_N:      m = qat_pkg::CH_LF;
      qat_pkg::CH_R:      m = qat_pkg::CH_CR;
      qat_pkg::CH_T:      m = qat_pkg::CH_TAB;
      qat_pkg::CH_BSLASH: m = qat_pkg::CH_BSLASH;
      default:            return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Lex one byte that has no backslash in front of it.
  function automatic void lex_plain(input logic [7:0] c,
                                    ref qat_pkg::result_t res[$]);
    if (tok_phase == qat_pkg::PH_QUOTED) begin
      if (c == qat_pkg::CH_QUOTE) tok_phase = qat_pkg::PH_PLAIN;
      else if (c == qat_pkg::CH_BSLASH) esc_wait = 1'b1;
      else res.push_back(char_item(c));
    end else if (c == qat_pkg::CH_SPACE) begin
      // A space closes an unquoted argument, then spaces are skipped.
      if (tok_phase == qat_pkg::PH_PLAIN) begin
        res.push_back(end_item());
        count_arg();
      end
      tok_phase = qat_pkg::PH_BETWEEN;
    end else if (c == qat_pkg::CH_QUOTE) begin
      tok_phase = qat_pkg::PH_QUOTED;
    end else begin
      tok_phase = qat_pkg::PH_PLAIN;
      if (c == qat_pkg::CH_BSLASH) esc_wait = 1'b1;
      else res.push_back(char_item(c));
    end
  endfunction

  // Advance the model by one accepted byte and queue what it yields.
  function automatic void tokenize_byte(input logic [7:0] c, input logic fin);
    qat_pkg::result_t res[$];
    qat_pkg::result_t close;
    logic [7:0]       mapped;
    if (esc_wait) begin
      esc_wait = 1'b0;
      if (escape_target(c, mapped)) begin
        res.push_back(char_item(mapped));
      end else begin
        // Unknown escape: pass the backslash on, then lex the byte as usual.
        res.push_back(char_item(qat_pkg::CH_BSLASH));
        lex_plain(c, res);
      end
    end else begin
      lex_plain(c, res);
    end
    if (fin) begin
      close = '0;
      close.line_done = 1'b1;
      // A dangling backslash at line end still goes out as a character.
      if (esc_wait) res.push_back(char_item(qat_pkg::CH_BSLASH));
      if (tok_phase == qat_pkg::PH_QUOTED) begin
        // Open quote at line end: drop the argument, do not count it.
        close.arg_dropped = 1'b1;
      end else if (tok_phase == qat_pkg::PH_PLAIN) begin
        close.arg_end = 1'b1;
        count_arg();
      end
      close.arg_total = arg_cnt;
      res.push_back(close);
      tok_phase = qat_pkg::PH_BETWEEN;
      esc_wait  = 1'b0;
      arg_cnt   = 8'd0;
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) owed_results.push_back(res[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] tokenizer error: %s", $realtime, msg);
  endtask

  // Compare every accepted result with the oldest owed one.
  always @(posedge clk) begin
    qat_pkg::result_t got;
    qat_pkg::result_t want;
    string            diff;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.char_out    = out_ch.char_out;
      got.char_valid  = out_ch.char_valid;
      got.arg_end     = out_ch.arg_end;
      got.arg_dropped = out_ch.arg_dropped;
      got.line_done   = out_ch.line_done;
      got.arg_total   = out_ch.arg_total;
      got.last        = out_ch.last;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = owed_results.pop_front();
        diff = "";
        if (got.char_out !== want.char_out)       diff = {diff, " char_out"};
        if (got.char_valid !== want.char_valid)   diff = {diff, " char_valid"};
        if (got.arg_end !== want.arg_end)         diff = {diff, " arg_end"};
        if (got.arg_dropped !== want.arg_dropped) diff = {diff, " arg_dropped"};
        if (got.line_done !== want.line_done)     diff = {diff, " line_done"};
        if (got.arg_total !== want.arg_total)     diff = {diff, " arg_total"};
        if (got.last !== want.last)               diff = {diff, " last"};
        if (diff != "")
          report_mismatch($sformatf("field(s)%s differ: got %h want %h",
                                    diff, got, want));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus long hold-offs counted here.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_request;
      hold_request = 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  // Offer one byte, idling at random first; leave valid up on return so a
  // back-to-back byte follows with no gap in valid.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.byte_in   <= b;
    in_ch.line_last <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tokenize_byte(b, fin);
  endtask

  // Send a whole line; the final byte carries line_last.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // Drop valid and hold off until the block owes nothing.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Idling pattern: 0 = slow sender/slower receiver, 1 = swapped, 2 = none.
  task automatic set_idling(input int mode);
    case (mode)
      0: begin snd_idle_pct = 35; rcv_idle_pct = 49; end
      1: begin snd_idle_pct = 49; rcv_idle_pct = 35; end
      default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
    endcase
  endtask

  // Random byte that lexes as ordinary argument text.
  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == qat_pkg::CH_SPACE || b == qat_pkg::CH_QUOTE ||
           b == qat_pkg::CH_BSLASH);
    return b;
  endfunction

  // Random escape sequence: mostly known escapes, sometimes an unknown one.
  function automatic void add_escape(ref logic [7:0] q[$]);
    q.push_back(qat_pkg::CH_BSLASH);
    case ($urandom_range(5))
      0: q.push_back(qat_pkg::CH_QUOTE);
      1: q.push_back(qat_pkg::CH_N);
      2: q.push_back(qat_pkg::CH_R);
      3: q.push_back(qat_pkg::CH_T);
      4: q.push_back(qat_pkg::CH_BSLASH);
      default: q.push_back(8'($urandom_range(255)));
    endcase
  endfunction

  // Build one command line from random tokens; a few lines are pure noise.
  function automatic void make_line(ref logic [7:0] q[$]);
    int n_tok;
    q.delete();
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(12, 1)) q.push_back(8'($urandom_range(255)));
      return;
    end
    n_tok = $urandom_range(8, 1);
    repeat (n_tok) begin
      case ($urandom_range(9))
        0, 1, 2: repeat ($urandom_range(4, 1)) q.push_back(word_byte());
        3, 4: begin
          // Quoted text with spaces and escapes; sometimes left open.
          q.push_back(qat_pkg::CH_QUOTE);
          repeat ($urandom_range(4)) begin
            case ($urandom_range(3))
              0: q.push_back(qat_pkg::CH_SPACE);
              1: add_escape(q);
              default: q.push_back(word_byte());
            endcase
          end
          if ($urandom_range(5) != 0) q.push_back(qat_pkg::CH_QUOTE);
        end
        5: add_escape(q);
        6, 7, 8: repeat ($urandom_range(3, 1)) q.push_back(qat_pkg::CH_SPACE);
        default: repeat ($urandom_range(3, 1)) q.push_back(8'($urandom_range(255)));
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Hand-made lines: every escape, quoting, empty argument, open quote at
  // line end, line end in an unquoted argument, backslash as final byte,
  // zero byte and the top byte value.
  task automatic test_directed_lines();
    send_text("\"a\\t\\\" b\" \\q\\\\");
    send_text("\"\" \\n\\r\"z");
    send_byte(qat_pkg::CH_SPACE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(qat_pkg::CH_BSLASH, 1'b1);
    wait_results_drained();
  endtask

  // Random well-formed lines mixed with noise, until enough bytes are sent.
  task automatic test_random_lines(input int n_bytes);
    logic [7:0] line_q[$];
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      make_line(line_q);
      foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
      sent += line_q.size();
    end
    wait_results_drained();
  endtask

  // Stall the receiver for a long stretch while bytes keep coming, so the
  // result queue fills and the input side must stall.
  task automatic test_output_backpressure();
    hold_request = 80;
    repeat (30) send_byte(word_byte(), 1'b0);
    send_byte(word_byte(), 1'b1);
    wait_results_drained();
  endtask

  initial begin
    int guard;
    in_ch.valid     = 1'b0;
    in_ch.byte_in   = 8'd0;
    in_ch.line_last = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0);
    test_directed_lines();
    test_random_lines(110);
    set_idling(1);
    test_random_lines(110);
    set_idling(2);
    test_random_lines(110);
    test_output_backpressure();

    // Drain with a bound, then give stray results time to show up.
    in_ch.valid <= 1'b0;
    guard = 0;
    while (owed_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (owed_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", owed_results.size()));

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
